// File: hw/rtl/bsca_pkg.sv
// bsca_pkg: shared types and constants of the bucket size class allocator
package bsca_pkg;

   localparam int unsigned UNITS_PER_PAGE = 256;
   localparam logic [8:0]  NULL_LINK      = 9'd256;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_PAGE   = 2'd2,
      STATUS_UNKNOWN   = 2'd3
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] request_size;
      logic [17:0] address;
   } req_payload_type;

   typedef struct packed {
      logic [17:0] granted_address;
      status_type  status;
   } rsp_payload_type;

   typedef struct packed {
      logic        in_use;
      logic [3:0]  page_class;
      logic [31:0] open_stamp;
      logic [8:0]  refcount;
      logic [8:0]  free_head;
   } page_rec_type;

   localparam page_rec_type PAGE_REC_CLEAR = '{
      in_use:     1'b0,
      page_class: 4'd0,
      open_stamp: 32'd0,
      refcount:   9'd0,
      free_head:  NULL_LINK
   };

endpackage

// File: hw/rtl/bucket_size_class_allocator.sv
// bucket_size_class_allocator: top level with the request sequencer and page scan
// After reset the block clears its page table, one page a cycle, and is not ready meanwhile.
// One item is handled at a time. A free reads the record of its page, if that page is in
// range, and then checks and updates it; an allocation scans the page table through a single
// memory read port, one page a cycle, and opens a new page when none is usable, writing its
// slot list into the link memory one entry a cycle. The result sits in an output register,
// and the next item is taken while it waits.
module bucket_size_class_allocator #(
   parameter int NUM_PAGES   = 64,
   parameter int NUM_CLASSES = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bsca_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bsca_pkg::rsp_payload_type rsp_payload
);

   localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam int AW = PW + 8;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_PICK, S_ALLOC_FIN,
      S_OPEN, S_OPEN_FIN, S_FREE_CHK, S_DONE
   } state_type;

   state_type                 state_ff;
   bsca_pkg::req_payload_type req_ff;
   bsca_pkg::rsp_payload_type res_ff;
   bsca_pkg::rsp_payload_type rsp_ff;
   logic                      rsp_valid_ff;
   logic [CW-1:0]             cnt_ff;
   logic                      rd_vld_ff;
   logic [PW-1:0]             rd_pg_ff;
   logic [3:0]                cls_ff;
   logic                      found_ff;
   logic [PW-1:0]             best_ff;
   logic [31:0]               best_stamp_ff;
   logic [8:0]                best_head_ff;
   logic [8:0]                best_ref_ff;
   logic                      free_found_ff;
   logic [PW-1:0]             free_pg_ff;
   logic [8:0]                open_u_ff;
   logic [31:0]               stamp_ff;

   logic                   pg_wr_en, pg_rd_en;
   logic [PW-1:0]          pg_wr_addr, pg_rd_addr;
   bsca_pkg::page_rec_type pg_wr_data, pg_q;
   logic                   ln_wr_en, ln_rd_en;
   logic [AW-1:0]          ln_wr_addr, ln_rd_addr;
   logic [8:0]             ln_wr_data, ln_q;

   // size class decode
   logic [3:0]  size_cls;
   logic        oversize;
   logic [10:0] fr_pg_wide;
   logic        fr_in_range;
   logic [PW-1:0] fr_pg;

   always_comb begin
      size_cls = 4'd0;
      oversize = 1'b1;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ((17'd16 << c) >= {1'b0, req_ff.request_size}) begin
            size_cls = 4'(c);
            oversize = 1'b0;
         end
      end
   end

   assign fr_pg_wide  = {5'd0, req_ff.address[17:12]};
   assign fr_in_range = fr_pg_wide < 11'(NUM_PAGES);
   assign fr_pg       = fr_pg_wide[PW-1:0];

   // free path arithmetic
   logic [7:0]  fr_unit;
   logic [8:0]  fr_ref;
   logic        fr_ok;
   logic [7:0]  cls_mask;

   assign cls_mask = 8'(9'h1FF << pg_q.page_class);
   assign fr_unit  = req_ff.address[11:4] & cls_mask;
   assign fr_ref   = (pg_q.refcount != 9'd0) ? pg_q.refcount - 9'd1 : 9'd0;
   assign fr_ok    = pg_q.in_use && ({28'd0, pg_q.page_class} < 32'(NUM_CLASSES))
                     && ((32'd16 << pg_q.page_class) >= {16'd0, req_ff.request_size});

   // page open sweep
   logic [8:0] step;
   logic [8:0] open_nxt;

   assign step     = 9'd1 << cls_ff;
   assign open_nxt = open_u_ff + step;

   logic [PW+11:0] best_addr_full, free_addr_full;
   assign best_addr_full = {best_ff, best_head_ff[7:0], 4'h0};
   assign free_addr_full = {free_pg_ff, 12'h000};

   logic scan_hit;
   assign scan_hit = rd_vld_ff && pg_q.in_use && (pg_q.page_class == cls_ff)
                     && !pg_q.free_head[8]
                     && (!found_ff || (pg_q.open_stamp > best_stamp_ff));

   always_comb begin
      pg_wr_en   = 1'b0;
      pg_wr_addr = cnt_ff[PW-1:0];
      pg_wr_data = bsca_pkg::PAGE_REC_CLEAR;
      pg_rd_en   = 1'b0;
      pg_rd_addr = cnt_ff[PW-1:0];
      ln_wr_en   = 1'b0;
      ln_wr_addr = {free_pg_ff, open_u_ff[7:0]};
      ln_wr_data = (open_nxt < bsca_pkg::NULL_LINK) ? open_nxt : bsca_pkg::NULL_LINK;
      ln_rd_en   = 1'b0;
      ln_rd_addr = {best_ff, best_head_ff[7:0]};
      unique case (state_ff)
         S_CLEAR: begin
            pg_wr_en = 1'b1;
         end
         S_DECODE: begin
            pg_rd_en   = (req_ff.mode == bsca_pkg::MODE_FREE) && fr_in_range;
            pg_rd_addr = fr_pg;
         end
         S_SCAN: begin
            pg_rd_en = cnt_ff < CW'(NUM_PAGES);
         end
         S_PICK: begin
            ln_rd_en = found_ff;
         end
         S_ALLOC_FIN: begin
            pg_wr_en   = 1'b1;
            pg_wr_addr = best_ff;
            pg_wr_data = '{in_use: 1'b1, page_class: cls_ff, open_stamp: best_stamp_ff,
                           refcount: (best_ref_ff < 9'd511) ? best_ref_ff + 9'd1 : best_ref_ff,
                           free_head: ln_q};
         end
         S_OPEN: begin
            ln_wr_en = 1'b1;
         end
         S_OPEN_FIN: begin
            pg_wr_en   = 1'b1;
            pg_wr_addr = free_pg_ff;
            pg_wr_data = '{in_use: 1'b1, page_class: cls_ff, open_stamp: stamp_ff + 32'd1,
                           refcount: 9'd1,
                           free_head: (step < bsca_pkg::NULL_LINK) ? step
                                                                   : bsca_pkg::NULL_LINK};
         end
         S_FREE_CHK: begin
            pg_wr_en   = fr_ok;
            pg_wr_addr = fr_pg;
            ln_wr_en   = fr_ok;
            ln_wr_addr = {fr_pg, fr_unit};
            ln_wr_data = pg_q.free_head;
            if (fr_ref == 9'd0) begin
               pg_wr_data            = bsca_pkg::PAGE_REC_CLEAR;
               pg_wr_data.open_stamp = pg_q.open_stamp;
            end else begin
               pg_wr_data = '{in_use: 1'b1, page_class: pg_q.page_class,
                              open_stamp: pg_q.open_stamp, refcount: fr_ref,
                              free_head: {1'b0, fr_unit}};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         stamp_ff      <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (cnt_ff == CW'(NUM_PAGES - 1)) begin
                  state_ff <= S_IDLE;
               end
               cnt_ff <= cnt_ff + CW'(1);
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_payload;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               cls_ff        <= size_cls;
               cnt_ff        <= '0;
               rd_vld_ff     <= 1'b0;
               found_ff      <= 1'b0;
               free_found_ff <= 1'b0;
               if (req_ff.mode == bsca_pkg::MODE_FREE) begin
                  if (fr_in_range) begin
                     state_ff <= S_FREE_CHK;
                  end else begin
                     res_ff   <= '{granted_address: 18'd0, status: bsca_pkg::STATUS_UNKNOWN};
                     state_ff <= S_DONE;
                  end
               end else if (oversize) begin
                  res_ff   <= '{granted_address: 18'd0, status: bsca_pkg::STATUS_TOO_LARGE};
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_vld_ff <= cnt_ff < CW'(NUM_PAGES);
               rd_pg_ff  <= cnt_ff[PW-1:0];
               if (cnt_ff < CW'(NUM_PAGES)) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               if (scan_hit) begin
                  found_ff      <= 1'b1;
                  best_ff       <= rd_pg_ff;
                  best_stamp_ff <= pg_q.open_stamp;
                  best_head_ff  <= pg_q.free_head;
                  best_ref_ff   <= pg_q.refcount;
               end
               if (rd_vld_ff && !pg_q.in_use && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_pg_ff    <= rd_pg_ff;
               end
               if (cnt_ff == CW'(NUM_PAGES) && !rd_vld_ff) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               open_u_ff <= '0;
               if (found_ff) begin
                  state_ff <= S_ALLOC_FIN;
               end else if (free_found_ff) begin
                  state_ff <= S_OPEN;
               end else begin
                  res_ff   <= '{granted_address: 18'd0, status: bsca_pkg::STATUS_NO_PAGE};
                  state_ff <= S_DONE;
               end
            end
            S_ALLOC_FIN: begin
               res_ff   <= '{granted_address: 18'(best_addr_full),
                             status: bsca_pkg::STATUS_OK};
               state_ff <= S_DONE;
            end
            S_OPEN: begin
               open_u_ff <= open_nxt;
               if (open_nxt >= bsca_pkg::NULL_LINK) begin
                  state_ff <= S_OPEN_FIN;
               end
            end
            S_OPEN_FIN: begin
               stamp_ff <= stamp_ff + 32'd1;
               res_ff   <= '{granted_address: 18'(free_addr_full),
                             status: bsca_pkg::STATUS_OK};
               state_ff <= S_DONE;
            end
            S_FREE_CHK: begin
               res_ff   <= '{granted_address: 18'd0,
                             status: fr_ok ? bsca_pkg::STATUS_OK : bsca_pkg::STATUS_UNKNOWN};
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   bsca_page_ram #(
      .NUM_PAGES (NUM_PAGES),
      .PW        (PW)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_wr_en),
      .wr_addr (pg_wr_addr),
      .wr_data (pg_wr_data),
      .rd_en   (pg_rd_en),
      .rd_addr (pg_rd_addr),
      .rd_data (pg_q)
   );

   bsca_link_ram #(
      .NUM_PAGES (NUM_PAGES),
      .AW        (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ln_wr_en),
      .wr_addr (ln_wr_addr),
      .wr_data (ln_wr_data),
      .rd_en   (ln_rd_en),
      .rd_addr (ln_rd_addr),
      .rd_data (ln_q)
   );

   // an error item never carries an address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != bsca_pkg::STATUS_OK)
      |-> rsp_payload.granted_address == 18'd0)
      else $error("error item with nonzero address");

   // scan counter stays within the page table
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(NUM_PAGES))
      else $error("scan counter beyond page table");

   // a page is only opened after a scan that found no usable page
   a_open_after_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPEN) && $past(state_ff == S_PICK) |-> !found_ff && free_found_ff)
      else $error("page opened while a usable page exists");

   // the result register is loaded only when the output side can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && (state_ff == S_DONE) |=> state_ff == S_DONE)
      else $error("pending item overwritten");

endmodule

// File: hw/rtl/bsca_page_ram.sv
// bsca_page_ram: per-page descriptor memory, one write and one registered read port
module bsca_page_ram #(
   parameter int NUM_PAGES = 64,
   parameter int PW        = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PW-1:0]         wr_addr,
   input  bsca_pkg::page_rec_type wr_data,
   input  logic                  rd_en,
   input  logic [PW-1:0]         rd_addr,
   output bsca_pkg::page_rec_type rd_data
);

   bsca_pkg::page_rec_type mem [NUM_PAGES];
   bsca_pkg::page_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bsca_link_ram.sv
// bsca_link_ram: free slot link memory, one write and one registered read port
module bsca_link_ram #(
   parameter int NUM_PAGES = 64,
   parameter int AW        = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [8:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [8:0]    rd_data
);

   logic [8:0] mem [NUM_PAGES * bsca_pkg::UNITS_PER_PAGE];
   logic [8:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
